// ===== rtl/uvsg_pkg.sv =====
// Shared types, constants and helper functions of the UV sphere mesh generator.
package uvsg_pkg;

    localparam int MAX_STACKS    = 256;
    localparam int MAX_SECTORS   = 256;
    localparam int POS_FRAC_BITS = 14;

    localparam int CNT_W  = 9;
    localparam int IDX_W  = 9;
    localparam int POS_W  = 16;
    localparam int TEX_W  = 17;
    localparam int CRN_W  = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register map, selected by paddr[2]
    localparam logic REG_STACK_COUNT  = 1'b0;
    localparam logic REG_SECTOR_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] STACK_RESET  = 9'd18;
    localparam logic [CNT_W-1:0] SECTOR_RESET = 9'd36;

    // Divider chain: one quotient bit per cell, four lanes side by side
    localparam int NUM_W      = 41;
    localparam int DIV_STAGES = NUM_W;
    localparam int QUO_W      = 32;
    localparam int REM_W      = 9;
    localparam int LANES      = 4;
    localparam int LANE_PH_V  = 0;
    localparam int LANE_PH_U  = 1;
    localparam int LANE_TEX_U = 2;
    localparam int LANE_TEX_V = 3;

    // Rotation chain: one CORDIC micro-rotation per cell
    localparam int CORDIC_STAGES = 32;
    localparam int CW            = 35;
    localparam int K_W           = 5;
    localparam logic signed [CW-1:0] CORDIC_K = 35'sh0_9B74_EDA8;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [IDX_W-1:0] stack_index;
        logic [IDX_W-1:0] sector_index;
    } t_point;

    typedef struct packed {
        t_kind                   kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [CRN_W-1:0]        corner_a;
        logic [CRN_W-1:0]        corner_b;
        logic [CRN_W-1:0]        corner_c;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0] stack_index;
        logic [IDX_W-1:0] sector_index;
        logic [CNT_W-1:0] stacks;
        logic [CNT_W-1:0] sectors;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
    } t_div;

    typedef struct packed {
        t_side            side;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } t_tag;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        t_rot u;
        t_rot v;
    } t_cord;

    // atan(2^-k) in Q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [K_W-1:0] k);
        logic [31:0] a;
        unique case (k)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            5'd31: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // A count of zero acts as one, a count above the limit as the limit.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] e;
        if (r == '0) begin
            e = CNT_W'(1);
        end else if (r > lim) begin
            e = lim;
        end else begin
            e = r;
        end
        return e;
    endfunction

endpackage

// ===== rtl/uvsg_div_cell.sv =====
// One restoring division step for four lanes, passing the word on to the next cell.
module uvsg_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uvsg_pkg::t_side i_side,
    input  uvsg_pkg::t_div  i_div,
    output logic            o_valid,
    output uvsg_pkg::t_side o_side,
    output uvsg_pkg::t_div  o_div
);
    import uvsg_pkg::*;

    logic             r_valid;
    t_side            r_side;
    t_div             r_div;
    t_div             n_div;
    logic [CNT_W-1:0] w_dv [LANES];
    logic [REM_W:0]   w_r2 [LANES];
    logic             w_ge [LANES];

    assign w_dv[LANE_PH_V]  = i_side.sectors;
    assign w_dv[LANE_TEX_U] = i_side.sectors;
    assign w_dv[LANE_PH_U]  = i_side.stacks;
    assign w_dv[LANE_TEX_V] = i_side.stacks;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < LANES; l++) begin
            w_r2[l] = {i_div.lane[l].rem, i_div.lane[l].num[NUM_W-1]};
            w_ge[l] = (w_r2[l] >= {1'b0, w_dv[l]});
            n_div.lane[l].num = {i_div.lane[l].num[NUM_W-2:0], 1'b0};
            n_div.lane[l].rem = w_ge[l] ? REM_W'(w_r2[l] - {1'b0, w_dv[l]})
                                        : w_r2[l][REM_W-1:0];
            n_div.lane[l].quo = {i_div.lane[l].quo[QUO_W-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= i_side;
        r_div  <= n_div;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

// ===== rtl/uvsg_cordic_cell.sv =====
// One CORDIC micro-rotation for the latitude and longitude angles.
module uvsg_cordic_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [uvsg_pkg::K_W-1:0] i_k,
    input  uvsg_pkg::t_tag           i_tag,
    input  uvsg_pkg::t_cord          i_cord,
    output logic                     o_valid,
    output uvsg_pkg::t_tag           o_tag,
    output uvsg_pkg::t_cord          o_cord
);
    import uvsg_pkg::*;

    logic  r_valid;
    t_tag  r_tag;
    t_cord r_cord;
    t_cord n_cord;

    function automatic t_rot rotate(input t_rot a, input logic [K_W-1:0] k);
        t_rot                 r;
        logic signed [CW-1:0] at;
        at = signed'({3'b000, atan_turn(k)});
        if (!a.z[CW-1]) begin
            r.x = a.x - (a.y >>> k);
            r.y = a.y + (a.x >>> k);
            r.z = a.z - at;
        end else begin
            r.x = a.x + (a.y >>> k);
            r.y = a.y - (a.x >>> k);
            r.z = a.z + at;
        end
        r.flip = a.flip;
        return r;
    endfunction

    always_comb begin
        n_cord.u = rotate(i_cord.u, i_k);
        n_cord.v = rotate(i_cord.v, i_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_tag  <= i_tag;
        r_cord <= n_cord;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_cord  = r_cord;

endmodule

// ===== rtl/uvsg_out.sv =====
// Scaling of the rotated vectors into positions and sequencing of the result words.
module uvsg_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  uvsg_pkg::t_tag    i_tag,
    input  uvsg_pkg::t_cord   i_cord,
    output logic              o_strobe,
    output uvsg_pkg::t_result o_result
);
    import uvsg_pkg::*;

    localparam int PROD_SH = 60 - POS_FRAC_BITS;
    localparam int Z_SH    = 30 - POS_FRAC_BITS;
    localparam logic signed [CW-1:0] RND_Q30 = 2;
    localparam logic signed [CW-1:0] SAT_Q30 = 1 << 30;
    localparam logic signed [63:0]   POS_LIM = 64'sd1 <<< POS_FRAC_BITS;

    typedef enum logic [2:0] {
        EMIT_IDLE = 3'b001,
        EMIT_TRI1 = 3'b010,
        EMIT_TRI2 = 3'b100
    } t_emit;

    function automatic logic signed [31:0] round_q30(input logic signed [CW-1:0] v,
                                                     input logic flip);
        logic signed [CW-1:0] nv;
        logic signed [CW-1:0] t;
        nv = flip ? -v : v;
        t  = (nv + RND_Q30) >>> 2;
        if (t > SAT_Q30) begin
            t = SAT_Q30;
        end else if (t < -SAT_Q30) begin
            t = -SAT_Q30;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [POS_W-1:0] round_pos(input logic signed [63:0] v,
                                                          input int sh);
        logic signed [63:0] h;
        logic signed [63:0] t;
        h = 64'sd1 <<< (sh - 1);
        t = (v + h) >>> sh;
        if (t > POS_LIM) begin
            t = POS_LIM;
        end else if (t < -POS_LIM) begin
            t = -POS_LIM;
        end
        return t[POS_W-1:0];
    endfunction

    // Stage 1: cosine and sine in Q30
    logic               r1_valid;
    t_tag               r1_tag;
    logic signed [31:0] r1_cu, r1_su, r1_cv, r1_sv;

    // Stage 2: products in Q60
    logic               r2_valid;
    t_tag               r2_tag;
    logic signed [63:0] r2_px, r2_py;
    logic signed [31:0] r2_su;

    // Stage 3: finished vertex and triangle indices
    logic                    r3_valid;
    t_tag                    r3_tag;
    logic signed [POS_W-1:0] r3_px, r3_py, r3_pz;
    logic [CRN_W-1:0]        r3_k1, r3_k2;
    logic                    r3_err, r3_t1, r3_t2;

    logic [18:0]      w_k1_full;
    logic [CRN_W-1:0] w_k1;
    logic             w_cell;

    // Emitter
    t_emit            r_state, n_state;
    logic [CRN_W-1:0] r_k1, r_k2;
    logic             r_t1, r_t2;
    logic             r_strobe, n_strobe;
    t_result          r_result, n_result;

    assign w_k1_full = 19'(r2_tag.side.stack_index) * (19'(r2_tag.side.sectors) + 19'd1)
                     + 19'(r2_tag.side.sector_index);
    assign w_k1      = w_k1_full[CRN_W-1:0];
    assign w_cell    = (r2_tag.side.stack_index < r2_tag.side.stacks)
                    && (r2_tag.side.sector_index < r2_tag.side.sectors);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        r1_tag <= i_tag;
        r1_cu  <= round_q30(i_cord.u.x, i_cord.u.flip);
        r1_su  <= round_q30(i_cord.u.y, i_cord.u.flip);
        r1_cv  <= round_q30(i_cord.v.x, i_cord.v.flip);
        r1_sv  <= round_q30(i_cord.v.y, i_cord.v.flip);

        r2_tag <= r1_tag;
        r2_px  <= r1_cu * r1_cv;
        r2_py  <= r1_cu * r1_sv;
        r2_su  <= r1_su;

        r3_tag <= r2_tag;
        r3_px  <= round_pos(r2_px, PROD_SH);
        r3_py  <= round_pos(r2_py, PROD_SH);
        r3_pz  <= round_pos({{32{r2_su[31]}}, r2_su}, Z_SH);
        r3_k1  <= w_k1;
        r3_k2  <= w_k1 + CRN_W'(r2_tag.side.sectors) + CRN_W'(1);
        r3_err <= (r2_tag.side.stack_index > r2_tag.side.stacks)
               || (r2_tag.side.sector_index > r2_tag.side.sectors);
        r3_t1  <= w_cell && (r2_tag.side.stack_index != '0);
        r3_t2  <= w_cell && (r2_tag.side.stack_index != r2_tag.side.stacks - CNT_W'(1));
    end

    // The busy window of the command port keeps items apart, so one vertex slot and two
    // triangle slots always fit before the next item shows up.
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_result = '0;
        if (r3_valid) begin
            n_strobe = 1'b1;
            n_state  = EMIT_TRI1;
            if (r3_err) begin
                n_result.kind = KIND_ERROR;
                n_result.last = 1'b1;
                n_state       = EMIT_IDLE;
            end else begin
                n_result.kind  = KIND_VERTEX;
                n_result.pos_x = r3_px;
                n_result.pos_y = r3_py;
                n_result.pos_z = r3_pz;
                n_result.tex_u = r3_tag.tex_u;
                n_result.tex_v = r3_tag.tex_v;
                n_result.last  = !(r3_t1 || r3_t2);
            end
        end else begin
            unique case (r_state)
                EMIT_IDLE: begin
                    n_state = EMIT_IDLE;
                end
                EMIT_TRI1: begin
                    n_state = EMIT_TRI2;
                    if (r_t1) begin
                        n_strobe          = 1'b1;
                        n_result.kind     = KIND_TRIANGLE;
                        n_result.corner_a = r_k1;
                        n_result.corner_b = r_k2;
                        n_result.corner_c = r_k1 + CRN_W'(1);
                        n_result.last     = !r_t2;
                    end
                end
                EMIT_TRI2: begin
                    n_state = EMIT_IDLE;
                    if (r_t2) begin
                        n_strobe          = 1'b1;
                        n_result.kind     = KIND_TRIANGLE;
                        n_result.corner_a = r_k1 + CRN_W'(1);
                        n_result.corner_b = r_k2;
                        n_result.corner_c = r_k2 + CRN_W'(1);
                        n_result.last     = 1'b1;
                    end
                end
                default: begin
                    n_state = EMIT_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= EMIT_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_result <= n_result;
        if (r3_valid) begin
            r_k1 <= r3_k1;
            r_k2 <= r3_k2;
            r_t1 <= r3_t1 && !r3_err;
            r_t2 <= r3_t2 && !r3_err;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/uv_sphere_mesh_generator_unit.sv =====
// Top level of the UV sphere mesh generator: register port, divider chain, CORDIC chain.
// A taken grid point passes the divider cells, the phase register, the CORDIC cells,
// the output stages and the result register; its triangle words, if any, follow it.
// A new grid point enters before the last is through, but busy holds off the next
// accept while the single result port carries a vertex and up to two triangles.
// Reset: synchronous, active low; stack and sector counts return to 18 and 36, pipeline
// empties. The receiver cannot stall, so every result word is shown exactly once.
module uv_sphere_mesh_generator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  uvsg_pkg::t_point              i_point,
    output logic                          o_strobe,
    output uvsg_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uvsg_pkg::ADDR_W-1:0]   paddr,
    input  logic [uvsg_pkg::DATA_W-1:0]   pwdata,
    output logic [uvsg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import uvsg_pkg::*;

    localparam logic [1:0]           GAP        = 2'd2;
    localparam logic [31:0]          PH_QUARTER = 32'h4000_0000;
    localparam logic signed [CW-1:0] TURN_QTR   = 35'sh0_4000_0000;
    localparam logic signed [CW-1:0] TURN_HALF  = 35'sh0_8000_0000;

    logic [CNT_W-1:0] r_stacks, r_sectors;
    logic [1:0]       r_gap;
    logic             w_accept, w_wr;
    logic [CNT_W-1:0] w_s, w_t;

    logic  w_dvld [DIV_STAGES+1];
    t_side w_side [DIV_STAGES+1];
    t_div  w_div  [DIV_STAGES+1];

    logic  r_pvld;
    t_tag  r_ptag;
    t_cord r_pcord;

    logic  w_cvld [CORDIC_STAGES+1];
    t_tag  w_tag  [CORDIC_STAGES+1];
    t_cord w_cord [CORDIC_STAGES+1];

    // Fold a turn phase into +-1/4 turn; the flip flag negates the result later.
    function automatic t_rot fold(input logic [31:0] ph);
        t_rot                 r;
        logic signed [CW-1:0] p;
        p      = signed'({{3{ph[31]}}, ph});
        r.flip = 1'b0;
        if (p > TURN_QTR) begin
            p      = p - TURN_HALF;
            r.flip = 1'b1;
        end else if (p < -TURN_QTR) begin
            p      = p + TURN_HALF;
            r.flip = 1'b1;
        end
        r.x = CORDIC_K;
        r.y = '0;
        r.z = p;
        return r;
    endfunction

    // Register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SECTOR_COUNT) ? DATA_W'(r_sectors) : DATA_W'(r_stacks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks  <= STACK_RESET;
            r_sectors <= SECTOR_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_STACK_COUNT) begin
                r_stacks <= pwdata[CNT_W-1:0];
            end else begin
                r_sectors <= pwdata[CNT_W-1:0];
            end
        end
    end

    // Command handshake
    assign busy     = (r_gap != 2'd0);
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_accept) begin
            r_gap <= GAP;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    assign w_s = eff_count(r_stacks, CNT_W'(MAX_STACKS));
    assign w_t = eff_count(r_sectors, CNT_W'(MAX_SECTORS));

    // Rounding by half the divisor is simply the low bits of each dividend.
    always_comb begin
        w_dvld[0]              = w_accept;
        w_side[0].stack_index  = i_point.stack_index;
        w_side[0].sector_index = i_point.sector_index;
        w_side[0].stacks       = w_s;
        w_side[0].sectors      = w_t;
        w_div[0]               = '0;
        w_div[0].lane[LANE_PH_V].num  = {i_point.sector_index, 32'(w_t[CNT_W-1:1])};
        w_div[0].lane[LANE_PH_U].num  = {1'b0, i_point.stack_index, 31'(w_s[CNT_W-1:1])};
        w_div[0].lane[LANE_TEX_U].num = {16'd0, i_point.sector_index, 16'(w_t[CNT_W-1:1])};
        w_div[0].lane[LANE_TEX_V].num = {16'd0, i_point.stack_index, 16'(w_s[CNT_W-1:1])};
    end

    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        uvsg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dvld[d]),
            .i_side  (w_side[d]),
            .i_div   (w_div[d]),
            .o_valid (w_dvld[d+1]),
            .o_side  (w_side[d+1]),
            .o_div   (w_div[d+1])
        );
    end

    // Phases in turns, then fold into the CORDIC range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= w_dvld[DIV_STAGES];
        end
        r_ptag.side  <= w_side[DIV_STAGES];
        r_ptag.tex_u <= w_div[DIV_STAGES].lane[LANE_TEX_U].quo[TEX_W-1:0];
        r_ptag.tex_v <= w_div[DIV_STAGES].lane[LANE_TEX_V].quo[TEX_W-1:0];
        r_pcord.u    <= fold(PH_QUARTER - w_div[DIV_STAGES].lane[LANE_PH_U].quo);
        r_pcord.v    <= fold(w_div[DIV_STAGES].lane[LANE_PH_V].quo);
    end

    assign w_cvld[0] = r_pvld;
    assign w_tag[0]  = r_ptag;
    assign w_cord[0] = r_pcord;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        uvsg_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cvld[k]),
            .i_k     (K_W'(k)),
            .i_tag   (w_tag[k]),
            .i_cord  (w_cord[k]),
            .o_valid (w_cvld[k+1]),
            .o_tag   (w_tag[k+1]),
            .o_cord  (w_cord[k+1])
        );
    end

    uvsg_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cvld[CORDIC_STAGES]),
        .i_tag    (w_tag[CORDIC_STAGES]),
        .i_cord   (w_cord[CORDIC_STAGES]),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== rtl/uvsg_checker.sv =====
// Port-level checks of the UV sphere mesh generator and their binding to the top level.
module uvsg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input uvsg_pkg::t_result           o_result
);
    import uvsg_pkg::*;

    // An accepted word raises busy, which drops again before the next word is taken.
    a_busy_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 busy ##1 !busy)
        else $error("busy window after an accepted word is wrong");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_ERROR) |->
        (o_result.last && o_result.pos_x == '0 && o_result.pos_z == '0
         && o_result.tex_u == '0 && o_result.corner_a == '0))
        else $error("out-of-range word is not a bare final word");

    a_tri_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_TRIANGLE) |->
        (o_result.pos_x == '0 && o_result.pos_y == '0 && o_result.tex_v == '0))
        else $error("triangle word carries vertex data");

    // A vertex that is not final is followed by a triangle word.
    a_tri_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_VERTEX && !o_result.last) |->
        ##[1:2] (o_strobe && o_result.kind == KIND_TRIANGLE))
        else $error("no triangle word after a vertex that is not final");

endmodule

bind uv_sphere_mesh_generator_unit uvsg_checker u_uvsg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/uv_sphere_mesh_generator_unit_test.sv =====
// Testbench of the UV sphere mesh generator: directed table, random grid points, CORDIC predictor.
`timescale 1ns / 100ps

module uv_sphere_mesh_generator_unit_test;
    import uvsg_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_PER_SET = 45;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };
    localparam longint ROT_GAIN = 64'sd2608131496;

    typedef struct {
        t_point  pt;
        bit      typed;
        t_result first;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_point              i_point;
    logic                o_strobe;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_result     pending_words[$];
    logic [8:0]  stacks_reg;
    logic [8:0]  sectors_reg;
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    t_row        rows[$];

    uv_sphere_mesh_generator_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_point  (i_point),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint round_down(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Cosine and sine of a phase in turns, both in Q30.
    task automatic turn_to_cos_sin(input logic [31:0] ph, output longint c, output longint s);
        longint p;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        p = longint'($signed(ph));
        flip = 1'b0;
        if (p > 64'sh40000000) begin
            p = p - 64'sh80000000;
            flip = 1'b1;
        end else if (p < -64'sh40000000) begin
            p = p + 64'sh80000000;
            flip = 1'b1;
        end
        x = ROT_GAIN;
        y = 0;
        z = p;
        for (int k = 0; k < 32; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - longint'(ATAN_TURNS[k]);
            end else begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + longint'(ATAN_TURNS[k]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp(round_down(x, 2), 64'sd1 <<< 30);
        s = clamp(round_down(y, 2), 64'sd1 <<< 30);
    endtask

    function automatic longint unsigned effective(input logic [8:0] r, input int lim);
        if (r == 0) return 1;
        if (r > lim) return lim;
        return r;
    endfunction

    // Works out every word that one grid point produces and queues it.
    task automatic predict_point(input t_point pt, output t_result words[$]);
        longint unsigned i;
        longint unsigned j;
        longint unsigned ns;
        longint unsigned nt;
        longint unsigned k1;
        longint unsigned k2;
        longint          cu;
        longint          su;
        longint          cv;
        longint          sv;
        logic [31:0]     ph_u;
        logic [31:0]     ph_v;
        longint          lim;
        t_result         w;
        words = {};
        i = pt.stack_index;
        j = pt.sector_index;
        ns = effective(stacks_reg, MAX_STACKS);
        nt = effective(sectors_reg, MAX_SECTORS);
        lim = 64'sd1 <<< POS_FRAC_BITS;
        w = '0;
        if (i > ns || j > nt) begin
            w.kind = KIND_ERROR;
            w.last = 1'b1;
            words = {words, w};
            return;
        end
        ph_u = 32'(64'h40000000 - (((i << 31) + ns / 2) / ns));
        ph_v = 32'(((j << 32) + nt / 2) / nt);
        turn_to_cos_sin(ph_u, cu, su);
        turn_to_cos_sin(ph_v, cv, sv);
        w.kind  = KIND_VERTEX;
        w.pos_x = POS_W'(clamp(round_down(cu * cv, 60 - POS_FRAC_BITS), lim));
        w.pos_y = POS_W'(clamp(round_down(cu * sv, 60 - POS_FRAC_BITS), lim));
        w.pos_z = POS_W'(clamp(round_down(su, 30 - POS_FRAC_BITS), lim));
        w.tex_u = TEX_W'((j * 65536 + nt / 2) / nt);
        w.tex_v = TEX_W'((i * 65536 + ns / 2) / ns);
        words = {words, w};
        if (i < ns && j < nt) begin
            k1 = i * (nt + 1) + j;
            k2 = k1 + nt + 1;
            w = '0;
            w.kind = KIND_TRIANGLE;
            if (i != 0) begin
                w.corner_a = CRN_W'(k1);
                w.corner_b = CRN_W'(k2);
                w.corner_c = CRN_W'(k1 + 1);
                words = {words, w};
            end
            if (i != ns - 1) begin
                w.corner_a = CRN_W'(k1 + 1);
                w.corner_b = CRN_W'(k2);
                w.corner_c = CRN_W'(k2 + 1);
                words = {words, w};
            end
        end
        words[words.size() - 1].last = 1'b1;
    endtask

    // After a random idle gap at times, holds start high until the block takes the point, then queues its words.
    task automatic send_point(input t_point pt, input bit typed, input t_result first);
        t_result words[$];
        int      gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start   <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (busy);
        predict_point(pt, words);
        if (typed) words[0] = first;
        pending_words = {pending_words, words};
    endtask

    task automatic write_register(input logic reg_sel, input logic [8:0] value);
        start <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {23'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_STACK_COUNT) stacks_reg = value;
        else sectors_reg = value;
    endtask

    function automatic t_row make_row(input int i, input int j, input bit typed,
                                      input t_result first);
        t_row r;
        r.pt.stack_index  = IDX_W'(i);
        r.pt.sector_index = IDX_W'(j);
        r.typed = typed;
        r.first = first;
        return r;
    endfunction

    // Result checker; the receiver cannot stall, so every strobe is a word.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", o_result);
            end else begin
                want = pending_words.pop_front();
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_result    none;
        t_result    pole;
        t_result    bad;
        t_point     pt;
        int         ns;
        int         nt;
        logic [8:0] set_s [8];
        logic [8:0] set_t [8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_point = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        stacks_reg = STACK_RESET;
        sectors_reg = SECTOR_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        none = '0;
        pole = '0;
        pole.kind  = KIND_VERTEX;
        pole.pos_z = 16'sd16384;
        bad = '0;
        bad.kind = KIND_ERROR;
        bad.last = 1'b1;
        rows = {rows, make_row(0, 0, 1'b1, pole)};
        rows = {rows, make_row(0, 36, 1'b0, none)};
        rows = {rows, make_row(18, 0, 1'b0, none)};
        rows = {rows, make_row(18, 36, 1'b0, none)};
        rows = {rows, make_row(17, 5, 1'b0, none)};
        rows = {rows, make_row(1, 35, 1'b0, none)};
        rows = {rows, make_row(9, 9, 1'b0, none)};
        rows = {rows, make_row(9, 18, 1'b0, none)};
        rows = {rows, make_row(19, 0, 1'b1, bad)};
        rows = {rows, make_row(0, 37, 1'b1, bad)};
        rows = {rows, make_row(511, 511, 1'b1, bad)};
        rows = {rows, make_row(256, 256, 1'b1, bad)};
        rows = {rows, make_row(170, 85, 1'b1, bad)};
        rows = {rows, make_row(5, 27, 1'b0, none)};
        foreach (rows[n]) send_point(rows[n].pt, rows[n].typed, rows[n].first);

        // Count settings: zero, single stack, single sector, the largest, above the largest, random, reset.
        set_s = '{9'd0, 9'd1, 9'd2, 9'd256, 9'd511, 9'd0, 9'd18, 9'd18};
        set_t = '{9'd0, 9'd3, 9'd1, 9'd256, 9'd300, 9'd0, 9'd36, 9'd36};
        set_s[5] = 9'($urandom_range(3, 60));
        set_t[5] = 9'($urandom_range(3, 60));
        for (int s = 0; s < 8; s++) begin
            write_register(REG_STACK_COUNT, set_s[s]);
            write_register(REG_SECTOR_COUNT, set_t[s]);
            ns = int'(effective(stacks_reg, MAX_STACKS));
            nt = int'(effective(sectors_reg, MAX_SECTORS));
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                if ($urandom_range(0, 9) < 8) begin
                    pt.stack_index  = IDX_W'($urandom_range(0, ns));
                    pt.sector_index = IDX_W'($urandom_range(0, nt));
                end else begin
                    pt = t_point'(18'($urandom));
                end
                send_point(pt, 1'b0, none);
            end
        end
        start <= 1'b0;

        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
